FILE: rtl/fskd_pkg.sv
// Shared types and constants for the FSK frame deframer.
// Used by fskd_core, fskd_res_fifo and fsk_frame_deframer; depends on nothing.
`default_nettype none

package fskd_pkg;

	// Configuration register indexes on the write port.
	localparam logic REG_EXPECTED_VERSION = 1'b0;
	localparam logic REG_BLOCK_LIMIT      = 1'b1;

	localparam logic [3:0] EXPECTED_VERSION_RESET = 4'd2;
	localparam logic [7:0] BLOCK_LIMIT_RESET      = 8'd125;

	// Result kinds.
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Frame status codes.
	localparam logic [2:0] ST_PARSED       = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION  = 3'd2;
	localparam logic [2:0] ST_BLOCKS_RANGE = 3'd3;
	localparam logic [2:0] ST_FEC_PAYLOAD  = 3'd4;

	// Result queue geometry.
	localparam int RESQ_AW    = 3;
	localparam int RESQ_DEPTH = 1 << RESQ_AW;

	typedef struct packed {
		logic [3:0] expected_version;
		logic [7:0] block_limit;
	} cfg_t;

	// One result item, without the text length, whose width follows a parameter.
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [2:0] code;
		logic       crc_ok;
		logic [3:0] version;
		logic       use_fec;
		logic [7:0] blocks;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/fskd_core.sv
// Per-symbol deframing logic: Gray decode, byte pairing, header vote, CRC and status.
// Uses fskd_pkg for the configuration and result types and the status codes.
`default_nettype none

module fskd_core #(
	parameter int MAX_PAYLOAD_BYTES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fskd_pkg::cfg_t     cfg,
	input  wire logic               sym_valid,
	input  wire logic [3:0]         tone,
	input  wire logic               last,
	output logic [1:0]              res_count,
	output logic [$bits(fskd_pkg::res_t)+$clog2(MAX_PAYLOAD_BYTES+1)-1:0] res0,
	output logic [$bits(fskd_pkg::res_t)+$clog2(MAX_PAYLOAD_BYTES+1)-1:0] res1
);

	localparam int TLEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam logic [TLEN_W-1:0] TLEN_MAX = TLEN_W'(MAX_PAYLOAD_BYTES);
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0]  SPACE    = 8'h20;
	localparam logic [4:0]  PAYLOAD_FIRST_SYMBOL = 5'd16;
	localparam logic [4:0]  SYMBOL_WRAP          = 5'd18;
	localparam logic [4:0]  LAST_SHORT_SYMBOL    = 5'd15;
	localparam logic [3:0]  HDR_BYTES  = 4'd6;
	localparam logic [3:0]  HDR_LAST   = 4'd5;
	localparam logic [3:0]  CRC_HI     = 4'd6;
	localparam logic [3:0]  CRC_LO     = 4'd7;

	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] vote3(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		return (a & b) | (a & c) | (b & c);
	endfunction

	logic [4:0]        sym_q, sym_n;
	logic [3:0]        hi_q, hi_n;
	logic [7:0]        hdr_q [HDR_BYTES];
	logic [15:0]       voted_q, voted_n;
	logic [15:0]       rcrc_q, rcrc_n;
	logic [15:0]       crun_q, crun_n;
	logic [15:0]       ccom_q, ccom_n;
	logic              space_q, space_n;
	logic [TLEN_W-1:0] kept_q, kept_n;
	logic [TLEN_W-1:0] total_q, total_n;
	logic [2:0]        perr_q, perr_n;

	logic [3:0]        nib;
	logic [7:0]        byte_v;
	logic [3:0]        k;
	logic [7:0]        h0, h1;
	logic              pay_valid;
	fskd_pkg::res_t    pay, stat;
	logic [TLEN_W-1:0] stat_tlen;
	logic [15:0]       crc_final;

	assign nib    = tone ^ (tone >> 1) ^ (tone >> 2) ^ (tone >> 3);
	assign byte_v = {hi_q, nib};
	assign k      = sym_q[4:1];
	assign h0     = vote3(hdr_q[0], hdr_q[2], hdr_q[4]);
	assign h1     = vote3(hdr_q[1], hdr_q[3], byte_v);

	always_comb begin
		sym_n     = sym_q + 5'd1;
		hi_n      = hi_q;
		voted_n   = voted_q;
		rcrc_n    = rcrc_q;
		crun_n    = crun_q;
		ccom_n    = ccom_q;
		space_n   = space_q;
		kept_n    = kept_q;
		total_n   = total_q;
		perr_n    = perr_q;
		pay_valid = 1'b0;
		if (sym_n >= SYMBOL_WRAP) begin
			sym_n = PAYLOAD_FIRST_SYMBOL;
		end
		if (!sym_q[0]) begin
			hi_n = nib;
		end else if (k < HDR_BYTES) begin
			// The sixth header byte completes all three copies, so the vote runs now.
			if (k == HDR_LAST) begin
				voted_n = {h0, h1};
				if (h0[7:4] != cfg.expected_version) begin
					perr_n = fskd_pkg::ST_BAD_VERSION;
				end else if (h1 > cfg.block_limit) begin
					perr_n = fskd_pkg::ST_BLOCKS_RANGE;
				end else if (h0[0] && (h1 != 8'd0)) begin
					perr_n = fskd_pkg::ST_FEC_PAYLOAD;
				end else begin
					perr_n = fskd_pkg::ST_PARSED;
				end
				crun_n = crc16_byte(crc16_byte(CRC_INIT, h0), h1);
				ccom_n = crun_n;
			end
		end else if (k == CRC_HI) begin
			rcrc_n[15:8] = byte_v;
		end else if (k == CRC_LO) begin
			rcrc_n[7:0] = byte_v;
		end else begin
			if (total_q < TLEN_MAX) begin
				total_n = total_q + TLEN_W'(1);
			end
			crun_n = crc16_byte(crun_q, byte_v);
			// Zero bytes are padding until a later nonzero byte proves otherwise.
			if (byte_v != 8'd0) begin
				ccom_n  = crun_n;
				space_n = (byte_v == SPACE);
				kept_n  = total_n;
			end
			pay_valid = (perr_q == fskd_pkg::ST_PARSED);
		end
	end

	always_comb begin
		pay      = '0;
		pay.kind = fskd_pkg::KIND_BYTE;
		pay.data = byte_v;

		crc_final = space_n ? ccom_n : crc16_byte(ccom_n, SPACE);
		stat_tlen = '0;
		stat      = '0;
		stat.kind = fskd_pkg::KIND_STATUS;
		stat.last = 1'b1;
		if (sym_q < LAST_SHORT_SYMBOL) begin
			stat.code = fskd_pkg::ST_TOO_SHORT;
		end else if (perr_n == fskd_pkg::ST_BAD_VERSION) begin
			stat.code = fskd_pkg::ST_BAD_VERSION;
		end else begin
			stat.code    = perr_n;
			stat.version = voted_n[15:12];
			stat.use_fec = voted_n[8];
			stat.blocks  = voted_n[7:0];
			if (perr_n == fskd_pkg::ST_PARSED) begin
				stat.crc_ok = (crc_final == rcrc_n);
				stat_tlen   = (space_n && (kept_n != '0)) ? kept_n - TLEN_W'(1) : kept_n;
			end
		end
	end

	assign res_count = sym_valid ? ({1'b0, pay_valid} + {1'b0, last}) : 2'd0;
	assign res0      = pay_valid ? {pay, {TLEN_W{1'b0}}} : {stat, stat_tlen};
	assign res1      = {stat, stat_tlen};

	always_ff @(posedge clk) begin
		if (sym_valid && sym_q[0] && (k < HDR_BYTES)) begin
			hdr_q[sym_q[3:1]] <= byte_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q   <= '0;
			hi_q    <= '0;
			voted_q <= '0;
			rcrc_q  <= '0;
			crun_q  <= CRC_INIT;
			ccom_q  <= CRC_INIT;
			space_q <= 1'b0;
			kept_q  <= '0;
			total_q <= '0;
			perr_q  <= fskd_pkg::ST_PARSED;
		end else if (sym_valid) begin
			if (last) begin
				sym_q   <= '0;
				hi_q    <= '0;
				voted_q <= '0;
				rcrc_q  <= '0;
				crun_q  <= CRC_INIT;
				ccom_q  <= CRC_INIT;
				space_q <= 1'b0;
				kept_q  <= '0;
				total_q <= '0;
				perr_q  <= fskd_pkg::ST_PARSED;
			end else begin
				sym_q   <= sym_n;
				hi_q    <= hi_n;
				voted_q <= voted_n;
				rcrc_q  <= rcrc_n;
				crun_q  <= crun_n;
				ccom_q  <= ccom_n;
				space_q <= space_n;
				kept_q  <= kept_n;
				total_q <= total_n;
				perr_q  <= perr_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fskd_res_fifo.sv
// Result queue: takes up to two results per cycle and hands out one.
// Uses fskd_pkg for the queue depth.
`default_nettype none

module fskd_res_fifo #(
	parameter int DATA_W = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [1:0]              push_count,
	input  wire logic [DATA_W-1:0]       push0,
	input  wire logic [DATA_W-1:0]       push1,
	input  wire logic                    pop,
	output logic [DATA_W-1:0]            rd_data,
	output logic [fskd_pkg::RESQ_AW:0]   count
);

	localparam int AW = fskd_pkg::RESQ_AW;

	logic [DATA_W-1:0] mem_q [fskd_pkg::RESQ_DEPTH];
	logic [AW-1:0]     wptr_q, rptr_q;
	logic [AW:0]       cnt_q;

	assign rd_data = mem_q[rptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wptr_q + AW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + AW'(push_count);
			rptr_q <= rptr_q + AW'(pop);
			cnt_q  <= cnt_q + (AW+1)'(push_count) - (AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fsk_frame_deframer.sv
// A symbol request is held in the input register; its results then enter the result queue.
// Throughput: one symbol per cycle; the frame-end symbol may yield two results,
// which leave the eight-entry result queue one per cycle while out_stall is low.
// Input stalls once fewer than two queue entries are free, or fewer than four
// while the input register holds a request.
// Reset clears the frame state, the queue and restores expected_version 2, block_limit 125.
`default_nettype none

module fsk_frame_deframer #(
	parameter int MAX_PAYLOAD_BYTES = 4096
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [3:0] tone_index,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            item_kind,
	output logic [7:0]      data_byte,
	output logic [2:0]      status_code,
	output logic            crc_ok,
	output logic [$clog2(MAX_PAYLOAD_BYTES+1)-1:0] text_length,
	output logic [3:0]      version,
	output logic            use_fec,
	output logic [7:0]      block_count,
	output logic            run_last
);

	localparam int TLEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int RES_W  = $bits(fskd_pkg::res_t) + TLEN_W;
	localparam logic [fskd_pkg::RESQ_AW:0] ROOM_IDLE =
		(fskd_pkg::RESQ_AW+1)'(fskd_pkg::RESQ_DEPTH - 2);
	localparam logic [fskd_pkg::RESQ_AW:0] ROOM_BUSY =
		(fskd_pkg::RESQ_AW+1)'(fskd_pkg::RESQ_DEPTH - 4);

	fskd_pkg::cfg_t             cfg_q;
	logic                       valid_s1;
	logic [3:0]                 tone_s1;
	logic                       end_s1;
	logic [1:0]                 res_count;
	logic [RES_W-1:0]           res0, res1, rd_data;
	logic [fskd_pkg::RESQ_AW:0] q_count;
	fskd_pkg::res_t             head;

	// Room is kept for the request in the input register and for the one being taken.
	assign in_stall = valid_s1 ? (q_count > ROOM_BUSY) : (q_count > ROOM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= fskd_pkg::EXPECTED_VERSION_RESET;
			cfg_q.block_limit      <= fskd_pkg::BLOCK_LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				fskd_pkg::REG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data[3:0];
				fskd_pkg::REG_BLOCK_LIMIT:      cfg_q.block_limit      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tone_s1 <= tone_index;
			end_s1  <= frame_end;
		end
	end

	fskd_core #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sym_valid (valid_s1),
		.tone      (tone_s1),
		.last      (end_s1),
		.res_count (res_count),
		.res0      (res0),
		.res1      (res1)
	);

	fskd_res_fifo #(
		.DATA_W(RES_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (res_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (out_valid && !out_stall),
		.rd_data    (rd_data),
		.count      (q_count)
	);

	assign out_valid   = (q_count != '0);
	assign head        = rd_data[RES_W-1:TLEN_W];
	assign text_length = rd_data[TLEN_W-1:0];
	assign item_kind   = head.kind;
	assign data_byte   = head.data;
	assign status_code = head.code;
	assign crc_ok      = head.crc_ok;
	assign version     = head.version;
	assign use_fec     = head.use_fec;
	assign block_count = head.blocks;
	assign run_last    = head.last;

endmodule

`default_nettype wire

FILE: dv/tb_fsk_frame_deframer.sv
// Self-checking testbench for fsk_frame_deframer: builds FSK frames as tone symbols,
// predicts payload bytes and frame status in SystemVerilog, and compares every result.
// Depends on rtl/fskd_pkg.sv and rtl/fsk_frame_deframer.sv.
`timescale 1ns / 1ps

module tb_fsk_frame_deframer;

	localparam int          MAX_BYTES         = 4096;
	localparam int          FIRST_PAYLOAD_SYM = 16;
	localparam logic [15:0] CRC_POLY          = 16'h1021;
	localparam logic [15:0] CRC_SEED          = 16'hFFFF;
	localparam logic [7:0]  SPACE             = 8'h20;

	typedef struct packed {
		logic [3:0] tone;
		logic       last_sym;
	} tone_req_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  code;
		logic        ok;
		logic [12:0] tlen;
		logic [3:0]  ver;
		logic        fec;
		logic [7:0]  blocks;
		logic        last;
	} deframe_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = fskd_pkg::REG_EXPECTED_VERSION;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  tone_index = 4'h0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        item_kind;
	logic [7:0]  data_byte;
	logic [2:0]  status_code;
	logic        crc_ok;
	logic [12:0] text_length;
	logic [3:0]  version;
	logic        use_fec;
	logic [7:0]  block_count;
	logic        run_last;

	fsk_frame_deframer #(
		.MAX_PAYLOAD_BYTES(MAX_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.tone_index(tone_index),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_kind(item_kind),
		.data_byte(data_byte),
		.status_code(status_code),
		.crc_ok(crc_ok),
		.text_length(text_length),
		.version(version),
		.use_fec(use_fec),
		.block_count(block_count),
		.run_last(run_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stimulus and scoreboard storage.
	tone_req_t       pending_tones[$];
	tone_req_t       frame_buf[$];
	deframe_result_t expected_results[$];
	bit              bursts_on = 1'b0;
	int              tones_queued = 0;
	int              tones_taken = 0;
	int              frames_sent = 0;
	int              settings_used = 1;
	int              fail_count = 0;
	int              bytes_checked = 0;
	int              crc_good_seen = 0;
	int              status_seen[5] = '{default: 0};

	// Predictor copy of the registers and of the frame state.
	logic [3:0]  exp_ver = fskd_pkg::EXPECTED_VERSION_RESET;
	logic [7:0]  blk_limit = fskd_pkg::BLOCK_LIMIT_RESET;
	logic [13:0] sym_pos;
	logic [3:0]  hi_nib;
	logic [7:0]  hdr_copy[6];
	logic [15:0] hdr_word;
	logic [15:0] rx_crc;
	logic [15:0] crc_run;
	logic [15:0] crc_keep;
	logic        tail_space;
	logic [12:0] kept_len;
	logic [12:0] payload_len;
	logic [2:0]  hdr_err;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	function automatic string describe(input deframe_result_t r);
		return $sformatf({"kind=%0d data=%02h code=%0d crc_ok=%0d len=%0d",
			" ver=%0d fec=%0d blocks=%0d last=%0d"},
			r.kind, r.data, r.code, r.ok, r.tlen, r.ver, r.fec, r.blocks, r.last);
	endfunction

	task automatic clear_frame();
		sym_pos = '0;
		hi_nib = '0;
		foreach (hdr_copy[i])
			hdr_copy[i] = '0;
		hdr_word = '0;
		rx_crc = '0;
		crc_run = CRC_SEED;
		crc_keep = CRC_SEED;
		tail_space = 1'b0;
		kept_len = '0;
		payload_len = '0;
		hdr_err = fskd_pkg::ST_PARSED;
	endtask

	// Works out the results of one accepted symbol request.
	task automatic predict_deframe(input logic [3:0] tone, input logic last_sym);
		logic [3:0]      nib;
		logic [7:0]      b;
		logic [7:0]      h0;
		logic [7:0]      h1;
		logic [13:0]     pos;
		logic [15:0]     crc;
		logic [12:0]     tl;
		int              k;
		deframe_result_t r;
		nib = tone ^ (tone >> 1) ^ (tone >> 2) ^ (tone >> 3);
		pos = sym_pos;
		if (!pos[0]) begin
			hi_nib = nib;
		end else begin
			b = {hi_nib, nib};
			k = pos >> 1;
			if (k < 6) begin
				hdr_copy[k] = b;
				if (k == 5) begin
					// Bitwise majority over the three header copies.
					h0 = (hdr_copy[0] & hdr_copy[2]) | (hdr_copy[0] & hdr_copy[4]) |
						(hdr_copy[2] & hdr_copy[4]);
					h1 = (hdr_copy[1] & hdr_copy[3]) | (hdr_copy[1] & hdr_copy[5]) |
						(hdr_copy[3] & hdr_copy[5]);
					hdr_word = {h0, h1};
					if (h0[7:4] != exp_ver)
						hdr_err = fskd_pkg::ST_BAD_VERSION;
					else if (h1 > blk_limit)
						hdr_err = fskd_pkg::ST_BLOCKS_RANGE;
					else if (h0[0] && h1 != 8'h00)
						hdr_err = fskd_pkg::ST_FEC_PAYLOAD;
					else
						hdr_err = fskd_pkg::ST_PARSED;
					crc_run = crc_step(crc_step(CRC_SEED, h0), h1);
					crc_keep = crc_run;
				end
			end else if (k == 6) begin
				rx_crc[15:8] = b;
			end else if (k == 7) begin
				rx_crc[7:0] = b;
			end else begin
				if (payload_len < MAX_BYTES)
					payload_len++;
				crc_run = crc_step(crc_run, b);
				// Zero bytes are padding unless something nonzero follows them.
				if (b != 8'h00) begin
					crc_keep = crc_run;
					tail_space = (b == SPACE);
					kept_len = payload_len;
				end
				if (hdr_err == fskd_pkg::ST_PARSED) begin
					r = '0;
					r.kind = fskd_pkg::KIND_BYTE;
					r.data = b;
					expected_results.insert(expected_results.size(), r);
				end
			end
		end
		sym_pos = (pos + 1 >= FIRST_PAYLOAD_SYM + 2) ? 14'(FIRST_PAYLOAD_SYM) : pos + 14'd1;
		if (last_sym) begin
			r = '0;
			r.kind = fskd_pkg::KIND_STATUS;
			r.last = 1'b1;
			if (pos + 1 < FIRST_PAYLOAD_SYM) begin
				r.code = fskd_pkg::ST_TOO_SHORT;
			end else if (hdr_err == fskd_pkg::ST_BAD_VERSION) begin
				r.code = fskd_pkg::ST_BAD_VERSION;
			end else begin
				r.code = hdr_err;
				r.ver = hdr_word[15:12];
				r.fec = hdr_word[8];
				r.blocks = hdr_word[7:0];
				if (hdr_err == fskd_pkg::ST_PARSED) begin
					crc = crc_keep;
					tl = kept_len;
					if (tail_space) begin
						if (tl > 0)
							tl--;
					end else begin
						crc = crc_step(crc, SPACE);
					end
					r.ok = (crc == rx_crc);
					r.tlen = tl;
				end
			end
			expected_results.insert(expected_results.size(), r);
			clear_frame();
		end
	endtask

	// Symbol driver: one request held until taken, with random idle bursts.
	int gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tone_index <= 4'h0;
			frame_end <= 1'b0;
			gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_deframe(tone_index, frame_end);
				tones_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					in_valid <= 1'b0;
					gap--;
				end else if (bursts_on && $urandom_range(0, 7) == 0) begin
					in_valid <= 1'b0;
					gap = $urandom_range(0, 9);
				end else if (pending_tones.size() > 0) begin
					in_valid <= 1'b1;
					tone_index <= pending_tones[0].tone;
					frame_end <= pending_tones[0].last_sym;
					void'(pending_tones.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker, with random stall bursts.
	int              stall_left = 0;
	deframe_result_t seen;
	deframe_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {item_kind, data_byte, status_code, crc_ok, text_length, version,
					use_fec, block_count, run_last};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %s", describe(seen));
				end else begin
					want = expected_results.pop_front();
					if (want.kind == fskd_pkg::KIND_BYTE) begin
						bytes_checked++;
					end else begin
						status_seen[want.code]++;
						if (want.ok)
							crc_good_seen++;
					end
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch %0d: expected %s", fail_count, describe(want));
							$display("mismatch %0d: actual   %s", fail_count, describe(seen));
						end
					end
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (bursts_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 9);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Frame construction.
	task automatic push_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), {b[7:4] ^ (b[7:4] >> 1), 1'b0});
		frame_buf.insert(frame_buf.size(), {b[3:0] ^ (b[3:0] >> 1), 1'b0});
	endtask

	task automatic ship_frame();
		tone_req_t t;
		t = frame_buf[frame_buf.size() - 1];
		t.last_sym = 1'b1;
		frame_buf[frame_buf.size() - 1] = t;
		foreach (frame_buf[i])
			pending_tones.insert(pending_tones.size(), frame_buf[i]);
		tones_queued += frame_buf.size();
		frames_sent++;
		frame_buf.delete();
	endtask

	task automatic raw_frame(input int n);
		repeat (n)
			frame_buf.insert(frame_buf.size(), {4'($urandom), 1'b0});
		ship_frame();
	endtask

	task automatic build_frame(input logic [3:0] ver, input logic [3:0] flags,
			input logic [7:0] blocks, input int n_payload, input int zero_tail,
			input bit end_space, input bit crc_good, input int bad_copies,
			input bit odd_nibble);
		logic [7:0]  payload[$];
		logic [7:0]  hdr[2];
		logic [7:0]  b;
		logic [15:0] crc;
		int          last_nz;
		int          i;
		int          cp;
		hdr[0] = {ver, flags};
		hdr[1] = blocks;
		for (cp = 0; cp < 3; cp++) begin
			for (i = 0; i < 2; i++) begin
				b = hdr[i];
				if (cp < bad_copies)
					b = b ^ (($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255)));
				push_byte(b);
			end
		end
		for (i = 0; i < n_payload; i++) begin
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = SPACE;
				default: b = 8'($urandom);
			endcase
			payload.insert(payload.size(), b);
		end
		if (end_space && n_payload > 0)
			payload[n_payload - 1] = SPACE;
		repeat (zero_tail)
			payload.insert(payload.size(), 8'h00);
		last_nz = -1;
		foreach (payload[j])
			if (payload[j] != 8'h00)
				last_nz = j;
		crc = crc_step(crc_step(CRC_SEED, hdr[0]), hdr[1]);
		for (i = 0; i <= last_nz; i++)
			crc = crc_step(crc, payload[i]);
		if (last_nz < 0)
			crc = crc_step(crc, SPACE);
		else if (payload[last_nz] != SPACE)
			crc = crc_step(crc, SPACE);
		if (!crc_good)
			crc = crc ^ 16'($urandom_range(1, 65535));
		push_byte(crc[15:8]);
		push_byte(crc[7:0]);
		foreach (payload[j])
			push_byte(payload[j]);
		if (odd_nibble)
			frame_buf.insert(frame_buf.size(), {4'($urandom), 1'b0});
		ship_frame();
	endtask

	// Mostly well-formed frames for the current registers, some short or noise.
	task automatic rand_frame();
		int         pick;
		int         bad;
		logic [3:0] ver;
		logic [3:0] flags;
		logic [7:0] blocks;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			raw_frame($urandom_range(1, 15));
		end else if (pick < 13) begin
			raw_frame($urandom_range(16, 48));
		end else begin
			ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : exp_ver;
			flags = 4'($urandom);
			flags[0] = ($urandom_range(0, 4) == 0);
			blocks = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
				8'($urandom_range(0, blk_limit));
			pick = $urandom_range(0, 9);
			bad = (pick < 6) ? 0 : (pick < 9) ? 1 : 2;
			build_frame(ver, flags, blocks, $urandom_range(0, 12),
				$urandom_range(0, 1) ? $urandom_range(0, 3) : 0,
				$urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0, bad,
				$urandom_range(0, 6) == 0);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == fskd_pkg::REG_EXPECTED_VERSION)
			exp_ver = val[3:0];
		else
			blk_limit = val;
	endtask

	// Waits until every request is taken and every result has come, plus a margin.
	task automatic settle();
		do
			@(negedge clk);
		while (tones_taken != tones_queued || expected_results.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		clear_frame();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed frames under the reset register values.
		bursts_on = 1'b1;
		frame_buf.insert(frame_buf.size(), {4'hF, 1'b0});
		ship_frame();
		raw_frame(15);
		build_frame(4'd2, 4'h0, 8'd0, 0, 0, 0, 1, 0, 0);
		build_frame(4'd2, 4'h0, 8'd125, 6, 2, 1, 1, 0, 0);
		build_frame(4'd7, 4'h0, 8'd3, 3, 0, 0, 1, 0, 0);
		build_frame(4'd2, 4'h0, 8'd126, 2, 0, 0, 1, 0, 0);
		build_frame(4'd2, 4'h1, 8'd5, 2, 0, 0, 1, 0, 0);
		build_frame(4'd2, 4'h0, 8'd10, 4, 1, 0, 0, 1, 1);
		build_frame(4'd2, 4'h0, 8'd10, 3, 0, 0, 1, 2, 0);
		build_frame(4'd2, 4'h0, 8'd1, 0, 3, 0, 1, 0, 0);
		settle();

		// Register extremes.
		write_reg(fskd_pkg::REG_EXPECTED_VERSION, 8'd0);
		write_reg(fskd_pkg::REG_BLOCK_LIMIT, 8'd0);
		settings_used++;
		build_frame(4'd0, 4'h0, 8'd0, 3, 0, 0, 1, 0, 0);
		build_frame(4'd0, 4'h0, 8'd1, 2, 0, 0, 1, 0, 0);
		build_frame(4'd15, 4'h0, 8'd0, 2, 0, 0, 1, 0, 0);
		build_frame(4'd0, 4'h1, 8'd0, 2, 0, 1, 1, 0, 0);
		settle();
		write_reg(fskd_pkg::REG_EXPECTED_VERSION, 8'd15);
		write_reg(fskd_pkg::REG_BLOCK_LIMIT, 8'd255);
		settings_used++;
		build_frame(4'd15, 4'hE, 8'd255, 4, 0, 0, 1, 1, 0);
		build_frame(4'd15, 4'hF, 8'd255, 2, 0, 0, 1, 0, 0);
		build_frame(4'd15, 4'h0, 8'd255, 5, 1, 1, 0, 0, 1);
		settle();

		// Random phases, each under its own register setting.
		while (tones_queued < 430) begin
			write_reg(fskd_pkg::REG_EXPECTED_VERSION, ($urandom_range(0, 2) == 0) ?
				8'($urandom_range(0, 15)) : 8'(fskd_pkg::EXPECTED_VERSION_RESET));
			write_reg(fskd_pkg::REG_BLOCK_LIMIT, 8'($urandom_range(0, 255)));
			settings_used++;
			bursts_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 6))
				rand_frame();
			settle();
		end

		// Closing stretch without idling on either side.
		bursts_on = 1'b0;
		repeat (4)
			rand_frame();
		settle();

		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", expected_results.size());
		end
		$display("Ran %0d frames (%0d symbols) under %0d register settings, %0d bytes checked.",
			frames_sent, tones_queued, settings_used, bytes_checked);
		$display("Status items: parsed %0d (crc good %0d), short %0d, bad version %0d,",
			status_seen[fskd_pkg::ST_PARSED], crc_good_seen,
			status_seen[fskd_pkg::ST_TOO_SHORT], status_seen[fskd_pkg::ST_BAD_VERSION]);
		$display("  block range %0d, fec %0d.",
			status_seen[fskd_pkg::ST_BLOCKS_RANGE], status_seen[fskd_pkg::ST_FEC_PAYLOAD]);
		if (fail_count == 0)
			$display("tb_fsk_frame_deframer OK");
		else
			$display("tb_fsk_frame_deframer NOT OK");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d results still expected", expected_results.size());
		$display("tb_fsk_frame_deframer NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fskd_pkg.sv
rtl/fskd_core.sv
rtl/fskd_res_fifo.sv
rtl/fsk_frame_deframer.sv
dv/tb_fsk_frame_deframer.sv
